// ----- rtl/bcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block boundary chunk splitter package
// Shared widths, configuration register indexes, reset values and input opcodes.
// ----------------------------------------------------------------------------
package bcs_pkg;

  // Byte offsets and range lengths.
  localparam int OFS_W = 48;
  // Block size and chunk length.
  localparam int BS_W  = 33;
  // Server index.
  localparam int SRV_W = 8;
  // Iteration counter of the divider, one step per offset bit.
  localparam int CNT_W = $clog2(OFS_W);

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = BS_W;

  localparam logic [CFG_INDEX_W-1:0] REG_BLK_BYTES    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVER_INDEX = 1'd1;

  localparam logic [BS_W-1:0] BLK_BYTES_RESET = BS_W'(4096);

  // Input opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

// ----- rtl/bcs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block boundary chunk splitter channels
// Valid/ready channels for the request beats and the result beats.
// ----------------------------------------------------------------------------
interface bcs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [bcs_pkg::OFS_W-1:0] range_length;
  logic [bcs_pkg::OFS_W-1:0] range_offset;

  modport source (output valid, output opcode, output range_length, output range_offset,
                  input ready);
  modport sink   (input valid, input opcode, input range_length, input range_offset,
                  output ready);
endinterface

interface bcs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      has_chunk;
  logic [bcs_pkg::SRV_W-1:0] target_server;
  logic [bcs_pkg::BS_W-1:0]  chunk_length;
  logic [bcs_pkg::OFS_W-1:0] chunk_offset;
  logic [bcs_pkg::OFS_W-1:0] block_number;

  modport source (output valid, output has_chunk, output target_server,
                  output chunk_length, output chunk_offset, output block_number,
                  input ready);
  modport sink   (input valid, input has_chunk, input target_server,
                  input chunk_length, input chunk_offset, input block_number,
                  output ready);
endinterface

// ----- rtl/block_boundary_chunk_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block boundary chunk splitter
// Hands out a loaded byte range as chunks that never cross a block boundary.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries request beats. A load beat (opcode 0) stores the
// range length and start offset; it gives no result and the block is ready
// again in the next cycle. A step beat (opcode 1) gives exactly one result
// beat on the rsp channel: the next chunk (offset, block number and a length
// that ends at the next block boundary or at the end of the range) for the
// configured server, or a beat with has_chunk low once the range is used up.
// A step with length left passes through the radix-2 divider, which yields
// the block number and the offset within the block one bit per offset bit,
// then takes its quotient and goes through states for room, chunk length,
// state update and hand-off to the result register; the next beat is taken
// once the block is back in idle. A step on a finished range goes straight
// to the hand-off with an all-zero result. While the receiver stalls, the
// output register holds its beat and a later result waits in its own
// register, holding off the input until the slot frees. Reset empties the
// output, clears the range and sets the block size to 4096 and server_index
// to 0. The user writes configuration via cfg_write, cfg_index and cfg_data
// while idle; the block does not enforce it. A block size of zero acts as one.
// ----------------------------------------------------------------------------
module block_boundary_chunk_splitter (
  input  logic                             clk,
  input  logic                             rst,
  bcs_req_if.sink                          req,
  bcs_rsp_if.source                        rsp,
  input  logic                             cfg_write,
  input  logic [bcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROOM,
    S_LEN,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [bcs_pkg::BS_W-1:0]  blk_bytes;
  logic [bcs_pkg::SRV_W-1:0] server_index;

  // Range state.
  logic [bcs_pkg::OFS_W-1:0] remaining_length;
  logic [bcs_pkg::OFS_W-1:0] current_offset;

  // Working registers for one step.
  logic [bcs_pkg::BS_W-1:0]  bs_eff;
  logic [bcs_pkg::BS_W-1:0]  room;
  logic [bcs_pkg::BS_W-1:0]  len;

  // Pending result, waiting for the output slot.
  logic                      res_has;
  logic [bcs_pkg::BS_W-1:0]  res_len;
  logic [bcs_pkg::OFS_W-1:0] res_off;
  logic [bcs_pkg::OFS_W-1:0] res_blk;

  // Output register.
  logic                      out_valid;
  logic                      out_has;
  logic [bcs_pkg::SRV_W-1:0] out_srv;
  logic [bcs_pkg::BS_W-1:0]  out_len;
  logic [bcs_pkg::OFS_W-1:0] out_off;
  logic [bcs_pkg::OFS_W-1:0] out_blk;

  logic                      req_fire;
  logic                      div_start;
  logic                      div_done;
  logic [bcs_pkg::OFS_W-1:0] div_quo;
  logic [bcs_pkg::BS_W-1:0]  div_rem;
  logic [bcs_pkg::BS_W-1:0]  bs_now;
  logic                      slot_free;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  // A zero block size behaves as a block of one byte.
  assign bs_now    = (blk_bytes == '0) ? bcs_pkg::BS_W'(1) : blk_bytes;
  assign div_start = req_fire && (req.opcode == bcs_pkg::OP_STEP) &&
                     (remaining_length != '0);

  assign slot_free = !out_valid || rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.has_chunk     = out_has;
  assign rsp.target_server = out_srv;
  assign rsp.chunk_length  = out_len;
  assign rsp.chunk_offset  = out_off;
  assign rsp.block_number  = out_blk;

  bcs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (current_offset),
    .divisor   (bs_now),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      blk_bytes        <= bcs_pkg::BLK_BYTES_RESET;
      server_index     <= '0;
      remaining_length <= '0;
      current_offset   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bcs_pkg::REG_BLK_BYTES:    blk_bytes    <= cfg_data;
          bcs_pkg::REG_SERVER_INDEX: server_index <= cfg_data[bcs_pkg::SRV_W-1:0];
          default: ;
        endcase
      end

      // A new beat enters the output slot when it is free; otherwise the slot
      // empties once the receiver takes its beat.
      if ((state == S_EMIT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.opcode == bcs_pkg::OP_LOAD) begin
              remaining_length <= req.range_length;
              current_offset   <= req.range_offset;
            end else if (remaining_length == '0) begin
              // Finished range: an all-zero result, state unchanged.
              res_has <= 1'b0;
              res_len <= '0;
              res_off <= '0;
              res_blk <= '0;
              state   <= S_EMIT;
            end else begin
              bs_eff <= bs_now;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_blk <= div_quo;
            state   <= S_ROOM;
          end
        end
        S_ROOM: begin
          // The remainder is below the block size, so the room is at least one.
          room  <= bs_eff - div_rem;
          state <= S_LEN;
        end
        S_LEN: begin
          if (remaining_length < {{(bcs_pkg::OFS_W-bcs_pkg::BS_W){1'b0}}, room}) begin
            len <= remaining_length[bcs_pkg::BS_W-1:0];
          end else begin
            len <= room;
          end
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          res_has          <= 1'b1;
          res_len          <= len;
          res_off          <= current_offset;
          remaining_length <= remaining_length -
                              {{(bcs_pkg::OFS_W-bcs_pkg::BS_W){1'b0}}, len};
          current_offset   <= current_offset +
                              {{(bcs_pkg::OFS_W-bcs_pkg::BS_W){1'b0}}, len};
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_has <= res_has;
            out_srv <= res_has ? server_index : '0;
            out_len <= res_len;
            out_off <= res_off;
            out_blk <= res_blk;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bcs_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block boundary chunk splitter divider
// Radix-2 restoring divider: offset by block size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bcs_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bcs_pkg::OFS_W-1:0] dividend,
  input  logic [bcs_pkg::BS_W-1:0]  divisor,
  output logic                      done,
  output logic [bcs_pkg::OFS_W-1:0] quotient,
  output logic [bcs_pkg::BS_W-1:0]  remainder
);

  logic                      busy;
  logic [bcs_pkg::CNT_W-1:0] cnt;
  logic [bcs_pkg::BS_W-1:0]  dsr;
  logic [bcs_pkg::BS_W:0]    trial;
  logic                      fits;

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one subtraction restores it.
  assign trial = {remainder, quotient[bcs_pkg::OFS_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= bcs_pkg::CNT_W'(bcs_pkg::OFS_W - 1);
        dsr       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (fits) begin
          remainder <= bcs_pkg::BS_W'(trial - {1'b0, dsr});
        end else begin
          remainder <= trial[bcs_pkg::BS_W-1:0];
        end
        quotient <= {quotient[bcs_pkg::OFS_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - bcs_pkg::CNT_W'(1);
        end
      end
    end
  end

endmodule
